FILE: sv/stt_pkg.sv
// Shared types and constants for the software timer table.
// Used by stt_alu, stt_core and software_timer_table_unit; no dependencies.
package stt_pkg;

	localparam int SLOTS    = 8;
	localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int HANDLE_W = 4;
	localparam int TIME_W   = 32;
	localparam int OP_W     = 3;

	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_CREATE     = 3'd1;
	localparam logic [OP_W-1:0] OP_SET_PERIOD = 3'd2;
	localparam logic [OP_W-1:0] OP_RELOAD     = 3'd3;
	localparam logic [OP_W-1:0] OP_DELETE     = 3'd4;

	localparam logic KIND_CREATE = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 8;

	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [HANDLE_W-1:0] handle;
		logic [TIME_W-1:0]   period;
		logic                auto_reload;
		logic                start_enabled;
		logic [TIME_W-1:0]   now;
	} cmd_t;

	typedef struct packed {
		logic                kind;
		logic [HANDLE_W-1:0] handle_out;
		logic                last;
	} res_t;

	function automatic logic [HANDLE_W-1:0] handle_of(input logic [IDX_W-1:0] idx);
		handle_of = HANDLE_W'(idx) + HANDLE_W'(1);
	endfunction

endpackage

FILE: sv/stt_alu.sv
// Shared adder and unsigned compare used by the tick, create and
// reload steps. Depends on stt_pkg.
module stt_alu (
	input  logic [stt_pkg::TIME_W-1:0] now,
	input  logic [stt_pkg::TIME_W-1:0] addend,
	input  logic [stt_pkg::TIME_W-1:0] expiry,
	output logic [stt_pkg::TIME_W-1:0] sum,
	output logic                       due
);
	import stt_pkg::*;

	assign sum = now + addend;
	assign due = (now >= expiry);

endmodule

FILE: sv/stt_core.sv
// Slot storage and sequencer: walks the slots one per cycle through stt_alu
// unless stalled on out_free. Depends on stt_pkg and stt_alu.
module stt_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  stt_pkg::cmd_t cmd,
	output logic          ready,
	input  logic          out_free,
	output logic          emit_valid,
	output stt_pkg::res_t emit
);
	import stt_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_FLUSH = 3'd2;
	localparam logic [2:0] ST_FIND  = 3'd3;
	localparam logic [2:0] ST_CMD   = 3'd4;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  idx_q;
	cmd_t              cmd_q;
	logic [SLOTS-1:0]  used_q;
	logic [SLOTS-1:0]  active_q;
	logic [SLOTS-1:0]  repeat_q;
	logic [TIME_W-1:0] period_q [SLOTS];
	logic [TIME_W-1:0] expiry_q [SLOTS];
	logic              pend_q;
	logic [IDX_W-1:0]  pend_idx_q;

	logic [TIME_W-1:0] addend;
	logic [TIME_W-1:0] sum;
	logic              due;
	logic              hit;
	logic              last_idx;
	logic              hdl_ok;

	assign addend   = (cmd_q.opcode == OP_CREATE) ? cmd_q.period : period_q[idx_q];
	assign hit      = used_q[idx_q] && active_q[idx_q] && due;
	assign last_idx = (idx_q == IDX_W'(SLOTS - 1));
	assign hdl_ok   = (cmd.handle != '0) && (32'(cmd.handle) <= 32'(SLOTS));
	assign ready    = (state_q == ST_IDLE);

	stt_alu u_alu (
		.now    (cmd_q.now),
		.addend (addend),
		.expiry (expiry_q[idx_q]),
		.sum    (sum),
		.due    (due)
	);

	always_comb begin
		emit_valid      = 1'b0;
		emit.kind       = KIND_EXPIRY;
		emit.handle_out = handle_of(pend_idx_q);
		emit.last       = 1'b0;
		unique case (state_q)
			ST_SCAN: begin
				emit_valid = hit && pend_q && out_free;
			end
			ST_FLUSH: begin
				emit_valid = pend_q && out_free;
				emit.last  = 1'b1;
			end
			ST_FIND: begin
				emit_valid      = out_free && (!used_q[idx_q] || last_idx);
				emit.kind       = KIND_CREATE;
				emit.handle_out = used_q[idx_q] ? '0 : handle_of(idx_q);
				emit.last       = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_SCAN && hit && (!pend_q || out_free) && repeat_q[idx_q]) begin
			expiry_q[idx_q] <= sum;
		end
		if (state_q == ST_FIND && out_free && !used_q[idx_q]) begin
			period_q[idx_q] <= cmd_q.period;
			if (cmd_q.start_enabled) begin
				expiry_q[idx_q] <= sum;
			end
		end
		if (state_q == ST_CMD && used_q[idx_q]) begin
			if (cmd_q.opcode == OP_SET_PERIOD) begin
				period_q[idx_q] <= cmd_q.period;
			end
			if (cmd_q.opcode == OP_RELOAD) begin
				expiry_q[idx_q] <= sum;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			idx_q      <= '0;
			used_q     <= '0;
			active_q   <= '0;
			repeat_q   <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						idx_q  <= '0;
						pend_q <= 1'b0;
						unique case (cmd.opcode)
							OP_TICK:   state_q <= ST_SCAN;
							OP_CREATE: state_q <= ST_FIND;
							OP_SET_PERIOD, OP_RELOAD, OP_DELETE: begin
								if (hdl_ok) begin
									idx_q   <= IDX_W'(cmd.handle - HANDLE_W'(1));
									state_q <= ST_CMD;
								end
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_SCAN: begin
					if (!hit || !pend_q || out_free) begin
						if (hit) begin
							if (!repeat_q[idx_q]) begin
								active_q[idx_q] <= 1'b0;
							end
							pend_q     <= 1'b1;
							pend_idx_q <= idx_q;
						end
						if (last_idx) begin
							state_q <= ST_FLUSH;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_q || out_free) begin
						pend_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_FIND: begin
					if (!used_q[idx_q]) begin
						if (out_free) begin
							used_q[idx_q]   <= 1'b1;
							repeat_q[idx_q] <= cmd_q.auto_reload;
							active_q[idx_q] <= cmd_q.start_enabled;
							state_q         <= ST_IDLE;
						end
					end else if (last_idx) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				ST_CMD: begin
					if (cmd_q.opcode == OP_DELETE) begin
						used_q[idx_q]   <= 1'b0;
						active_q[idx_q] <= 1'b0;
					end else if (cmd_q.opcode == OP_RELOAD && used_q[idx_q]) begin
						active_q[idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: sv/software_timer_table_unit.sv
// Top level of the software timer table: stream ports and result register.
// Depends on stt_pkg and stt_core.
//
// Takes one command at a time. A tick walks all slots, one per cycle through a
// single shared adder and comparator, unless stalled on m_tready; each expired
// slot gives one result. A create walks until the lowest free slot and always
// gives one reply, also stalling on m_tready. Set period, reload and delete give
// no result; with a handle of zero or above SLOTS they, like unknown opcodes,
// are dropped. The table is empty after reset.
module software_timer_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// handle[3:0], period[35:4], auto_reload[36], start_enabled[37], now[69:38]
	input  logic [stt_pkg::IN_DATA_W-1:0] s_tdata,
	// opcode[2:0]
	input  logic [stt_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// handle_out[3:0]
	output logic [stt_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind[0]
	output logic                          m_tuser,
	output logic                          m_tlast
);
	import stt_pkg::*;

	cmd_t cmd;
	res_t emit;
	res_t res_q;
	logic emit_valid;
	logic out_free;
	logic valid_q;

	assign cmd.opcode        = s_tuser;
	assign cmd.handle        = s_tdata[3:0];
	assign cmd.period        = s_tdata[35:4];
	assign cmd.auto_reload   = s_tdata[36];
	assign cmd.start_enabled = s_tdata[37];
	assign cmd.now           = s_tdata[69:38];

	assign out_free = !valid_q || m_tready;

	stt_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (s_tvalid && s_tready),
		.cmd        (cmd),
		.ready      (s_tready),
		.out_free   (out_free),
		.emit_valid (emit_valid),
		.emit       (emit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit_valid) begin
			res_q <= emit;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {{(OUT_DATA_W - HANDLE_W){1'b0}}, res_q.handle_out};
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;

endmodule
